// ===== rtl/csa_pkg.sv =====
// shared types and constants of the contiguous segment allocator
package csa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int ADDR_BITS = 16;
  localparam int DATA_W = 16;
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int PADDR_W = 3;
  localparam logic [DATA_W-1:0] ADDR_MASK =
    (ADDR_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_COMPACT = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_MEM   = 3'd1,
    ST_DUP_ID   = 3'd2,
    ST_NO_HOLE  = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    REG_MEMORY_SIZE = 1'b0,
    REG_FIT_MODE    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t opcode;
    logic [DATA_W-1:0] block_id;
    logic [DATA_W-1:0] block_size;
  } in_beat_t;

  typedef struct packed {
    status_t status;
    logic [DATA_W-1:0] start_address;
    logic [DATA_W-1:0] free_remaining;
  } out_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic en;
    reg_idx_t idx;
    logic [DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_CHECK,
    DP_SCAN_RD,
    DP_SCAN_EV,
    DP_LAST,
    DP_PLACE,
    DP_ASH_RD,
    DP_ASH_WR,
    DP_INSERT,
    DP_FSH_RD,
    DP_FSH_WR,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    op_t op;
    logic too_big;
    logic idx_at_cnt;
    logic match;
    logic full;
    logic found;
    logic idx_at_best;
    logic fsh_last;
  } dp_stat_t;

endpackage

// ===== rtl/csa_datapath.sv =====
// segment table memory, scan arithmetic and result registers
module csa_datapath (
  input  logic               clk,
  input  logic               rst,
  input  csa_pkg::dp_cmd_t   cmd,
  output csa_pkg::dp_stat_t  stat,
  input  csa_pkg::in_beat_t  in_data,
  output csa_pkg::out_beat_t out_data,
  input  csa_pkg::cfg_wr_t   cfg,
  output logic [csa_pkg::DATA_W-1:0] memory_size,
  output logic               fit_mode
);

  csa_pkg::entry_t mem [csa_pkg::MAX_BLOCKS];
  csa_pkg::entry_t rdata;

  csa_pkg::op_t                  op;
  logic [csa_pkg::DATA_W-1:0]    id;
  logic [csa_pkg::DATA_W-1:0]    size;
  logic [csa_pkg::CNT_W-1:0]     idx;
  logic [csa_pkg::CNT_W-1:0]     cnt;
  logic [csa_pkg::DATA_W-1:0]    rem;
  logic [csa_pkg::DATA_W:0]      prev_end;
  logic [csa_pkg::DATA_W-1:0]    nxt_start;
  logic [csa_pkg::CNT_W-1:0]     best;
  logic [csa_pkg::DATA_W-1:0]    best_lo;
  logic [csa_pkg::DATA_W:0]      best_len;
  logic                          found;
  csa_pkg::status_t              res_status;
  logic [csa_pkg::DATA_W-1:0]    res_addr;

  logic [csa_pkg::DATA_W:0]      hole_hi;
  logic [csa_pkg::DATA_W:0]      hole_len;
  logic                          take;
  logic [csa_pkg::CNT_W-1:0]     idx_inc;
  logic [csa_pkg::CNT_W-1:0]     idx_dec;
  logic                          rd_en;
  logic [csa_pkg::IDX_W-1:0]     rd_idx;
  logic                          wr_en;
  logic [csa_pkg::IDX_W-1:0]     wr_idx;
  csa_pkg::entry_t               wr_data;

  assign idx_inc = idx + csa_pkg::CNT_W'(1);
  assign idx_dec = idx - csa_pkg::CNT_W'(1);

  // hole below the current entry, or above the last one up to memory_size
  always_comb begin
    hole_hi = (cmd.op == csa_pkg::DP_LAST) ? {1'b0, memory_size} : {1'b0, rdata.start};
    hole_len = (hole_hi >= prev_end) ? hole_hi - prev_end : '0;
    take = ({1'b0, size} <= hole_len) &&
           (!found || (fit_mode && hole_len <= best_len));
  end

  always_comb begin
    stat.op = op;
    stat.too_big = size > rem;
    stat.idx_at_cnt = idx == cnt;
    stat.match = rdata.id == id;
    stat.full = cnt == csa_pkg::CNT_MAX;
    stat.found = found;
    stat.idx_at_best = idx == best;
    stat.fsh_last = idx_inc >= cnt;
  end

  // memory port control
  always_comb begin
    rd_en = 1'b0;
    rd_idx = idx[csa_pkg::IDX_W-1:0];
    wr_en = 1'b0;
    wr_idx = idx[csa_pkg::IDX_W-1:0];
    wr_data = rdata;
    unique case (cmd.op)
      csa_pkg::DP_SCAN_RD: rd_en = !stat.idx_at_cnt;
      csa_pkg::DP_SCAN_EV: begin
        if (op == csa_pkg::OP_COMPACT) begin
          wr_en = 1'b1;
          wr_data = '{id: rdata.id, start: nxt_start, size: rdata.size};
        end
      end
      csa_pkg::DP_ASH_RD: begin
        rd_en = !stat.idx_at_best;
        rd_idx = idx_dec[csa_pkg::IDX_W-1:0];
      end
      csa_pkg::DP_ASH_WR: wr_en = 1'b1;
      csa_pkg::DP_INSERT: begin
        wr_en = 1'b1;
        wr_idx = best[csa_pkg::IDX_W-1:0];
        wr_data = '{id: id, start: best_lo & csa_pkg::ADDR_MASK, size: size};
      end
      csa_pkg::DP_FSH_RD: begin
        rd_en = !stat.fsh_last;
        rd_idx = idx_inc[csa_pkg::IDX_W-1:0];
      end
      csa_pkg::DP_FSH_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size <= '0;
      fit_mode <= 1'b0;
      cnt <= '0;
      rem <= '0;
    end else begin
      if (cfg.en) begin
        unique case (cfg.idx)
          csa_pkg::REG_MEMORY_SIZE: begin
            memory_size <= cfg.data & csa_pkg::ADDR_MASK;
            rem <= cfg.data & csa_pkg::ADDR_MASK;
            cnt <= '0;
          end
          csa_pkg::REG_FIT_MODE: fit_mode <= cfg.data[0];
        endcase
      end
      unique case (cmd.op)
        csa_pkg::DP_SCAN_EV: begin
          if (op == csa_pkg::OP_FREE && stat.match) begin
            rem <= (rem + rdata.size) & csa_pkg::ADDR_MASK;
          end
        end
        csa_pkg::DP_INSERT: begin
          cnt <= cnt + csa_pkg::CNT_W'(1);
          rem <= rem - size;
        end
        csa_pkg::DP_FSH_RD: begin
          if (stat.fsh_last) begin
            cnt <= idx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      csa_pkg::DP_LOAD: begin
        op <= in_data.opcode;
        id <= in_data.block_id;
        size <= in_data.block_size;
        idx <= '0;
        prev_end <= '0;
        nxt_start <= '0;
        found <= 1'b0;
        best <= '0;
        best_lo <= '0;
        best_len <= '0;
        res_status <= csa_pkg::ST_OK;
        res_addr <= '0;
      end
      csa_pkg::DP_CHECK: begin
        if (op == csa_pkg::OP_ALLOC && stat.too_big) begin
          res_status <= csa_pkg::ST_NO_MEM;
        end
      end
      csa_pkg::DP_SCAN_RD: begin
        if (stat.idx_at_cnt && op == csa_pkg::OP_FREE) begin
          res_status <= csa_pkg::ST_NOT_FOUND;
        end
      end
      csa_pkg::DP_SCAN_EV: begin
        unique case (op)
          csa_pkg::OP_ALLOC: begin
            if (stat.match) begin
              res_status <= csa_pkg::ST_DUP_ID;
            end
            if (take) begin
              found <= 1'b1;
              best <= idx;
              best_lo <= prev_end[csa_pkg::DATA_W-1:0];
              best_len <= hole_len;
            end
            prev_end <= {1'b0, rdata.start} + {1'b0, rdata.size};
            idx <= idx_inc;
          end
          csa_pkg::OP_FREE: begin
            if (!stat.match) begin
              idx <= idx_inc;
            end
          end
          csa_pkg::OP_COMPACT: begin
            nxt_start <= (nxt_start + rdata.size) & csa_pkg::ADDR_MASK;
            idx <= idx_inc;
          end
          default: ;
        endcase
      end
      csa_pkg::DP_LAST: begin
        if (stat.full) begin
          res_status <= csa_pkg::ST_FULL;
        end else if (take) begin
          found <= 1'b1;
          best <= idx;
          best_lo <= prev_end[csa_pkg::DATA_W-1:0];
          best_len <= hole_len;
        end
      end
      csa_pkg::DP_PLACE: begin
        if (!found) begin
          res_status <= csa_pkg::ST_NO_HOLE;
        end
        idx <= cnt;
      end
      csa_pkg::DP_ASH_WR: idx <= idx_dec;
      csa_pkg::DP_INSERT: res_addr <= best_lo & csa_pkg::ADDR_MASK;
      csa_pkg::DP_FSH_WR: idx <= idx_inc;
      csa_pkg::DP_OUT: begin
        out_data.status <= res_status;
        out_data.start_address <= res_addr;
        out_data.free_remaining <= rem;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= csa_pkg::CNT_MAX)
    else $error("entry count above table depth");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) rem <= memory_size)
    else $error("free space above memory size");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == csa_pkg::DP_INSERT && !cfg.en) |=> cnt == $past(cnt) + csa_pkg::CNT_W'(1))
    else $error("insert did not add an entry");
  a_dup_no_insert: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == csa_pkg::DP_INSERT) |-> (res_status == csa_pkg::ST_OK && found))
    else $error("insert after a failed check");
`endif

endmodule

// ===== rtl/csa_ctrl.sv =====
// command sequencer of the segment allocator
module csa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output csa_pkg::dp_cmd_t  cmd,
  input  csa_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_LAST,
    S_PLACE,
    S_ASH_RD,
    S_ASH_WR,
    S_INSERT,
    S_FSH_RD,
    S_FSH_WR,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.op = csa_pkg::DP_IDLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = csa_pkg::DP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = csa_pkg::DP_CHECK;
        if (stat.op == csa_pkg::OP_NOP ||
            (stat.op == csa_pkg::OP_ALLOC && stat.too_big)) begin
          state_next = S_FIN;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.op = csa_pkg::DP_SCAN_RD;
        if (!stat.idx_at_cnt) begin
          state_next = S_SCAN_EV;
        end else if (stat.op == csa_pkg::OP_ALLOC) begin
          state_next = S_LAST;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SCAN_EV: begin
        cmd.op = csa_pkg::DP_SCAN_EV;
        if (stat.match && stat.op == csa_pkg::OP_ALLOC) begin
          state_next = S_FIN;
        end else if (stat.match && stat.op == csa_pkg::OP_FREE) begin
          state_next = S_FSH_RD;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_LAST: begin
        cmd.op = csa_pkg::DP_LAST;
        state_next = stat.full ? S_FIN : S_PLACE;
      end
      S_PLACE: begin
        cmd.op = csa_pkg::DP_PLACE;
        state_next = stat.found ? S_ASH_RD : S_FIN;
      end
      S_ASH_RD: begin
        cmd.op = csa_pkg::DP_ASH_RD;
        state_next = stat.idx_at_best ? S_INSERT : S_ASH_WR;
      end
      S_ASH_WR: begin
        cmd.op = csa_pkg::DP_ASH_WR;
        state_next = S_ASH_RD;
      end
      S_INSERT: begin
        cmd.op = csa_pkg::DP_INSERT;
        state_next = S_FIN;
      end
      S_FSH_RD: begin
        cmd.op = csa_pkg::DP_FSH_RD;
        state_next = stat.fsh_last ? S_FIN : S_FSH_WR;
      end
      S_FSH_WR: begin
        cmd.op = csa_pkg::DP_FSH_WR;
        state_next = S_FSH_RD;
      end
      S_FIN: begin
        // wait until the output register is free
        if (out_free) begin
          cmd.op = csa_pkg::DP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !(state == S_IDLE))
    else $error("command finished without a result");
  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result beat not presented");
  a_idle_no_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !in_valid) |-> cmd.op == csa_pkg::DP_IDLE)
    else $error("datapath command while idle");
`endif

endmodule

// ===== rtl/contiguous_segment_allocator.sv =====
// top level of the contiguous segment allocator
//
//   channel  | handshake                     | beat
//   in       | in_valid / in_ready           | in_data (opcode, block_id, block_size)
//   out      | out_valid / out_ready         | out_data (status, start_address, free_remaining)
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// one command at a time; allocate, free and compact loop over the single-port segment table with
// registered read, stepping through the entries that they scan and move
// the output register holds a result while the next command is taken
// rst clears the table count, memory_size, fit_mode and the free count
module contiguous_segment_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  csa_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output csa_pkg::out_beat_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  csa_pkg::dp_cmd_t  cmd;
  csa_pkg::dp_stat_t stat;
  csa_pkg::cfg_wr_t  cfg;
  csa_pkg::reg_idx_t reg_sel;
  logic [csa_pkg::DATA_W-1:0] memory_size;
  logic fit_mode;

  assign pready = 1'b1;
  assign reg_sel = csa_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    cfg.en = psel && penable && pwrite;
    cfg.idx = reg_sel;
    cfg.data = pwdata[csa_pkg::DATA_W-1:0];
  end

  always_comb begin
    unique case (reg_sel)
      csa_pkg::REG_MEMORY_SIZE: prdata = {{(32 - csa_pkg::DATA_W){1'b0}}, memory_size};
      csa_pkg::REG_FIT_MODE:    prdata = {31'd0, fit_mode};
    endcase
  end

  csa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  csa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .out_data    (out_data),
    .cfg         (cfg),
    .memory_size (memory_size),
    .fit_mode    (fit_mode)
  );

endmodule
